// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define IHPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IHPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/ihpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ILBM HAM pixel decoder package
// Constants, codes and types shared by the decoder files.
// ----------------------------------------------------------------------------
package ihpd_pkg;

  localparam int PaletteDepth   = 256;
  localparam int PaletteAw      = $clog2(PaletteDepth);
  localparam int MaxPlanes      = 24;
  localparam int DirectPlanes   = 24;
  localparam int HamBaseEntries = 16;
  localparam int NibW           = $clog2(HamBaseEntries);

  localparam int ColorW    = 8;
  localparam int RgbW      = 3 * ColorW;
  localparam int PixelW    = 24;
  localparam int OpW       = 2;
  localparam int PlaneCntW = 5;
  localparam int PalSizeW  = 9;

  localparam int ApbAw = 4;
  localparam int ApbDw = 32;

  typedef enum logic [OpW-1:0] {
    OpDecode = 2'd0,
    OpWrite  = 2'd1,
    OpReload = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    HamLoad  = 2'd0,
    HamBlue  = 2'd1,
    HamRed   = 2'd2,
    HamGreen = 2'd3
  } ham_e;

  typedef enum logic [1:0] {
    RegHamMode     = 2'd0,
    RegPlaneCount  = 2'd1,
    RegPaletteSize = 2'd2
  } reg_e;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  function automatic logic [ColorW-1:0] repeat_nibble(logic [NibW-1:0] v);
    return {v, v};
  endfunction

endpackage

// ===== sv/ihpd_if.sv =====
// ----------------------------------------------------------------------------
// ILBM HAM pixel decoder channels
// Valid/ready channels for decoder requests and decoded pixels.
// ----------------------------------------------------------------------------
interface ihpd_in_if import ihpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [PixelW-1:0] plane_bits;
  logic [ColorW-1:0] entry_index;
  logic [ColorW-1:0] entry_red;
  logic [ColorW-1:0] entry_green;
  logic [ColorW-1:0] entry_blue;

  modport source (
    output valid, operation, plane_bits, entry_index, entry_red, entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, operation, plane_bits, entry_index, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

interface ihpd_out_if import ihpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;
  logic [ColorW-1:0] colour_index;
  logic              is_indexed;
  logic              out_of_range;

  modport source (
    output valid, red, green, blue, colour_index, is_indexed, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, colour_index, is_indexed, out_of_range,
    output ready
  );
endinterface

// ===== sv/ihpd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module ihpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ilbm_ham_pixel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ILBM HAM pixel decoder core
// Decodes bitplane pixels into RGB, HAM6 or palette index results.
// ----------------------------------------------------------------------------
// The core accepts one request per clock unless a stalled output blocks its
// colour stage. The palette RAM read is issued at acceptance, the held colour
// is updated and the result formed in the following stage, and the result
// waits in an output register, so a stalled output holds back at most the
// request in flight. Palette writes take effect at acceptance and palette
// reads happen in request order, so later requests always see earlier
// writes. The palette has no reset; reading an entry never written returns
// an undefined colour. Palette writes, held-colour reloads and unused codes
// give no result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ilbm_ham_pixel_decoder_core import ihpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [ApbDw-1:0] pwdata,
  output logic [ApbDw-1:0] prdata,
  output logic             pready,
  ihpd_in_if.sink          in_i,
  ihpd_out_if.source       out_o
);

  logic                 ham_mode_q;
  logic [PlaneCntW-1:0] plane_count_q;
  logic [PalSizeW-1:0]  palette_size_q;
  logic                 cfg_we;

  logic [PlaneCntW-1:0] n_eff;
  logic [PixelW-1:0]    mask0;
  logic [PixelW-1:0]    creg0;
  logic                 in_accept;
  logic                 ram_we;
  logic [PaletteAw-1:0] ram_raddr;
  logic [RgbW-1:0]      ram_rdata;

  logic              s1_valid_q;
  logic [OpW-1:0]    s1_op_q;
  logic [PixelW-1:0] s1_creg_q;
  logic              s1_fire;
  logic              s1_dec_fire;
  logic              out_free;

  rgb_t              pal;
  rgb_t              held_q, held_d;
  rgb_t              res_rgb;
  logic [ColorW-1:0] res_idx;
  logic              res_indexed;
  logic              res_oor;

  logic              out_valid_q;
  rgb_t              out_rgb_q;
  logic [ColorW-1:0] out_idx_q;
  logic              out_indexed_q;
  logic              out_oor_q;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ham_mode_q     <= 1'b0;
      plane_count_q  <= PlaneCntW'(6);
      palette_size_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        RegHamMode:     ham_mode_q     <= pwdata[0];
        RegPlaneCount:  plane_count_q  <= pwdata[PlaneCntW-1:0];
        RegPaletteSize: palette_size_q <= pwdata[PalSizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[3:2]))
      RegHamMode:     prdata = ApbDw'(ham_mode_q);
      RegPlaneCount:  prdata = ApbDw'(plane_count_q);
      RegPaletteSize: prdata = ApbDw'(palette_size_q);
      default:        prdata = '0;
    endcase
  end

  // Request stage: plane masking and palette access.
  always_comb begin
    n_eff = plane_count_q;
    if (plane_count_q == '0) begin
      n_eff = PlaneCntW'(1);
    end else if (plane_count_q > PlaneCntW'(MaxPlanes)) begin
      n_eff = PlaneCntW'(MaxPlanes);
    end
    for (int k = 0; k < PixelW; k++) begin
      mask0[k] = (k < int'(n_eff));
    end
  end

  assign creg0     = in_i.plane_bits & mask0;
  assign in_accept = in_i.valid && in_i.ready;
  assign ram_we    = in_accept && (in_i.operation == OpWrite)
                     && (32'(in_i.entry_index) < PaletteDepth);
  assign ram_raddr = (in_i.operation == OpReload) ? '0 : PaletteAw'(creg0[NibW-1:0]);

  ihpd_ram #(
    .Width (RgbW),
    .Depth (PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.entry_index[PaletteAw-1:0]),
    .wdata_i ({in_i.entry_red, in_i.entry_green, in_i.entry_blue}),
    .re_i    (in_accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake between stages.
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && ((s1_op_q != OpDecode) || out_free);
  assign s1_dec_fire = s1_fire && (s1_op_q == OpDecode);
  assign in_i.ready  = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= in_i.operation;
      s1_creg_q <= creg0;
    end
  end

  // Colour stage: held colour update and result selection.
  assign pal = rgb_t'(ram_rdata);

  always_comb begin
    held_d = held_q;
    if (s1_fire && (s1_op_q == OpReload)) begin
      held_d = pal;
    end else if (s1_dec_fire && ham_mode_q) begin
      unique case (ham_e'(s1_creg_q[5:4]))
        HamLoad:  held_d       = pal;
        HamBlue:  held_d.blue  = repeat_nibble(s1_creg_q[NibW-1:0]);
        HamRed:   held_d.red   = repeat_nibble(s1_creg_q[NibW-1:0]);
        HamGreen: held_d.green = repeat_nibble(s1_creg_q[NibW-1:0]);
        default:  held_d       = held_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  always_comb begin
    res_rgb     = '0;
    res_idx     = '0;
    res_indexed = 1'b0;
    res_oor     = 1'b0;
    if (ham_mode_q) begin
      res_rgb = held_d;
    end else if (plane_count_q >= PlaneCntW'(DirectPlanes)) begin
      res_rgb = rgb_t'(s1_creg_q);
    end else begin
      res_indexed = 1'b1;
      res_idx     = s1_creg_q[ColorW-1:0];
      res_oor     = (s1_creg_q >= PixelW'(palette_size_q));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_dec_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_dec_fire) begin
      out_rgb_q     <= res_rgb;
      out_idx_q     <= res_idx;
      out_indexed_q <= res_indexed;
      out_oor_q     <= res_oor;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red          = out_rgb_q.red;
  assign out_o.green        = out_rgb_q.green;
  assign out_o.blue         = out_rgb_q.blue;
  assign out_o.colour_index = out_idx_q;
  assign out_o.is_indexed   = out_indexed_q;
  assign out_o.out_of_range = out_oor_q;

  `IHPD_ASSERT(a_decode_reaches_output, s1_dec_fire |=> out_valid_q, "decode result lost")
  `IHPD_ASSERT(a_held_only_on_fire, !s1_fire |=> $stable(held_q), "held colour changed while idle")
  `IHPD_ASSERT(a_stall_blocks_input, (s1_valid_q && s1_op_q == OpDecode && out_valid_q && !out_o.ready) |-> !in_i.ready, "input taken while stage blocked")
  `IHPD_ASSERT_ALWAYS(a_reset_clears_output, !rst_ni |-> !out_o.valid, "output valid during reset")

endmodule
